// File: src/rpmd_pkg.sv
package rpmd_pkg;

	localparam int SPEED_WIDTH_DEF = 16;
	localparam int TIME_WIDTH_DEF  = 16;
	localparam int STEP_WIDTH      = 8;
	localparam int CFG_IDX_W       = 3;
	localparam int QUEUE_DEPTH     = 2;

	// command codes carried on the input channel and through the queue
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_SET   = 2'd1;
	localparam logic [1:0] OP_READY = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_MIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_MAX    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_INIT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_STEP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_PERIOD = 3'd6;

	// register values after reset
	localparam int SPEED_MIN_RST    = -255;
	localparam int SPEED_MAX_RST    = 255;
	localparam int SPEED_INIT_RST   = 0;
	localparam int SPEED_STEP_RST   = 1;
	localparam int PULSE_MIN_RST    = 0;
	localparam int PULSE_MAX_RST    = 0;
	localparam int PULSE_PERIOD_RST = 20000;

	typedef struct packed {
		logic motor_on;
		logic period_end;
		logic forward;
		logic target_zero;
	} rpmd_result_t;

	typedef struct packed {
		logic idle;
		logic map_wait;
		logic recompute_pend;
	} rpmd_back_stat_t;

endpackage

// File: src/rpmd_ifs.sv
interface rpmd_cmd_if import rpmd_pkg::*; #(
	parameter int SPEED_WIDTH = SPEED_WIDTH_DEF,
	parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic [1:0]                    op;
	logic signed [SPEED_WIDTH-1:0] target_value;
	logic [TIME_WIDTH-1:0]         tick_interval;

	modport source (output valid, op, target_value, tick_interval, input ready);
	modport sink (input valid, op, target_value, tick_interval, output ready);
endinterface

interface rpmd_status_if ();
	logic valid;
	logic ready;
	logic motor_on;
	logic period_end;
	logic forward;
	logic target_zero;

	modport source (output valid, motor_on, period_end, forward, target_zero, input ready);
	modport sink (input valid, motor_on, period_end, forward, target_zero, output ready);
endinterface

interface rpmd_cfg_if import rpmd_pkg::*; #(
	parameter int DATA_WIDTH = SPEED_WIDTH_DEF
) ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [DATA_WIDTH-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: src/ramped_pwm_motor_drive_core.sv
// Channel   Role  Transfer when          Carries
// cfg       sink  cfg.valid & ready      index, data (register write, always ready)
// cmd       sink  cmd.valid & ready      op, target_value, tick_interval
// status    src   status.valid & ready   motor_on, period_end, forward, target_zero
//
// Set, ready and plain ticks retire at the queue head: after the queue, status.valid is
// registered; one command a cycle streams through while status.ready keeps up.
// The first tick after a period end (or after reset or a ready command) first runs the
// ramp step and the on-time map: one multiply and a restoring divide of
// SPEED_WIDTH+TIME_WIDTH steps.
// Reset is asynchronous and active low; registers take their documented reset values.
// A two-entry queue lets cmd keep accepting while the back end maps or status stalls.
module ramped_pwm_motor_drive_core import rpmd_pkg::*; #(
	parameter int SPEED_WIDTH = SPEED_WIDTH_DEF,
	parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	rpmd_cfg_if.sink      cfg,
	rpmd_cmd_if.sink      cmd,
	rpmd_status_if.source status
);
	localparam int ENTRY_W = 2 + SPEED_WIDTH + TIME_WIDTH;

	// configuration registers
	logic [SPEED_WIDTH-1:0] speed_min_q;
	logic [SPEED_WIDTH-1:0] speed_max_q;
	logic [SPEED_WIDTH-1:0] speed_init_q;
	logic [STEP_WIDTH-1:0]  speed_step_q;
	logic [TIME_WIDTH-1:0]  pulse_min_q;
	logic [TIME_WIDTH-1:0]  pulse_max_q;
	logic [TIME_WIDTH-1:0]  pulse_period_q;

	// queue between front and back
	logic               q_push;
	logic               q_full;
	logic               q_pop;
	logic               q_empty;
	logic [ENTRY_W-1:0] q_entry;
	logic [ENTRY_W-1:0] q_head;

	// on-time map unit
	logic                   map_start;
	logic                   map_done;
	logic [TIME_WIDTH-1:0]  map_on_time;
	logic [SPEED_WIDTH-1:0] cur_speed;

	rpmd_back_stat_t back_stat;

	// Register writes must be made only while the block is idle; the block does not enforce this and takes them at once.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_min_q    <= SPEED_WIDTH'(SPEED_MIN_RST);
			speed_max_q    <= SPEED_WIDTH'(SPEED_MAX_RST);
			speed_init_q   <= SPEED_WIDTH'(SPEED_INIT_RST);
			speed_step_q   <= STEP_WIDTH'(SPEED_STEP_RST);
			pulse_min_q    <= TIME_WIDTH'(PULSE_MIN_RST);
			pulse_max_q    <= TIME_WIDTH'(PULSE_MAX_RST);
			pulse_period_q <= TIME_WIDTH'(PULSE_PERIOD_RST);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SPEED_MIN:    speed_min_q    <= cfg.data[SPEED_WIDTH-1:0];
				REG_SPEED_MAX:    speed_max_q    <= cfg.data[SPEED_WIDTH-1:0];
				REG_SPEED_INIT:   speed_init_q   <= cfg.data[SPEED_WIDTH-1:0];
				REG_SPEED_STEP:   speed_step_q   <= cfg.data[STEP_WIDTH-1:0];
				REG_PULSE_MIN:    pulse_min_q    <= cfg.data[TIME_WIDTH-1:0];
				REG_PULSE_MAX:    pulse_max_q    <= cfg.data[TIME_WIDTH-1:0];
				REG_PULSE_PERIOD: pulse_period_q <= cfg.data[TIME_WIDTH-1:0];
				default: begin
					// unknown index: drop the write
				end
			endcase
		end
	end

	// Front end: accept commands, clamp the target, push into the queue.
	rpmd_front #(
		.SPEED_WIDTH (SPEED_WIDTH),
		.TIME_WIDTH  (TIME_WIDTH)
	) u_front (
		.cmd       (cmd),
		.speed_min (speed_min_q),
		.speed_max (speed_max_q),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (q_entry)
	);

	rpmd_fifo #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_entry),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_head),
		.empty     (q_empty)
	);

	// Back end: hold the drive state, ramp, accumulate time, register the result.
	rpmd_back #(
		.SPEED_WIDTH (SPEED_WIDTH),
		.TIME_WIDTH  (TIME_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_head       (q_head),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.speed_init   (speed_init_q),
		.speed_step   (speed_step_q),
		.pulse_period (pulse_period_q),
		.cur_speed    (cur_speed),
		.map_start    (map_start),
		.map_done     (map_done),
		.map_on_time  (map_on_time),
		.status       (status),
		.stat         (back_stat)
	);

	// Linear map of speed onto the pulse range, multiply then bit-serial divide.
	rpmd_map #(
		.SPEED_WIDTH (SPEED_WIDTH),
		.TIME_WIDTH  (TIME_WIDTH)
	) u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (map_start),
		.cur_speed (cur_speed),
		.speed_min (speed_min_q),
		.speed_max (speed_max_q),
		.pulse_min (pulse_min_q),
		.pulse_max (pulse_max_q),
		.done      (map_done),
		.on_time   (map_on_time)
	);

`ifndef SYNTHESIS
	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue written while full");

	a_queue_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue read while empty");

	a_map_done_awaited: assert property (@(posedge clk) disable iff (!arst_n)
		map_done |-> back_stat.map_wait)
		else $error("map finished with no back end waiting");

	a_tick_after_recompute: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && (q_head[ENTRY_W-1 -: 2] == OP_TICK)) |-> !back_stat.recompute_pend)
		else $error("tick retired before the on-time was recomputed");
`endif

endmodule

// File: src/rpmd_fifo.sv
module rpmd_fifo #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: src/rpmd_front.sv
module rpmd_front import rpmd_pkg::*; #(
	parameter int SPEED_WIDTH = SPEED_WIDTH_DEF,
	parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
	rpmd_cmd_if.sink                          cmd,
	input  logic signed [SPEED_WIDTH-1:0]     speed_min,
	input  logic signed [SPEED_WIDTH-1:0]     speed_max,
	input  logic                              q_full,
	output logic                              q_push,
	output logic [2+SPEED_WIDTH+TIME_WIDTH-1:0] q_entry
);
	logic signed [SPEED_WIDTH-1:0] t_hi;
	logic signed [SPEED_WIDTH-1:0] t_clamp;
	logic [SPEED_WIDTH-1:0]        set_val;
	logic [TIME_WIDTH-1:0]         ivl;

	assign cmd.ready = !q_full;
	assign q_push    = cmd.valid && !q_full;

	// clamp to the upper limit first, the lower limit wins on a crossed pair
	assign t_hi    = (cmd.target_value > speed_max) ? speed_max : cmd.target_value;
	assign t_clamp = (t_hi < speed_min) ? speed_min : t_hi;

	// drop the field that the command does not use
	always_comb begin
		set_val = '0;
		ivl     = '0;
		case (cmd.op)
			OP_TICK: ivl = cmd.tick_interval;
			OP_SET:  set_val = t_clamp;
			default: begin
			end
		endcase
	end

	assign q_entry = {cmd.op, set_val, ivl};

endmodule

// File: src/rpmd_map.sv
module rpmd_map import rpmd_pkg::*; #(
	parameter int SPEED_WIDTH = SPEED_WIDTH_DEF,
	parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [SPEED_WIDTH-1:0]        cur_speed,
	input  logic [SPEED_WIDTH-1:0]        speed_min,
	input  logic [SPEED_WIDTH-1:0]        speed_max,
	input  logic [TIME_WIDTH-1:0]         pulse_min,
	input  logic [TIME_WIDTH-1:0]         pulse_max,
	output logic                          done,
	output logic [TIME_WIDTH-1:0]         on_time
);
	localparam int PROD_W = SPEED_WIDTH + TIME_WIDTH;
	localparam int CNT_W  = $clog2(PROD_W + 1);

	localparam logic [1:0] M_IDLE = 2'd0;
	localparam logic [1:0] M_MUL  = 2'd1;
	localparam logic [1:0] M_DIV  = 2'd2;
	localparam logic [1:0] M_FIN  = 2'd3;

	logic [1:0]             state_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [SPEED_WIDTH-1:0] ax_q;
	logic [TIME_WIDTH-1:0]  ay_q;
	logic [SPEED_WIDTH-1:0] den_q;
	logic                   neg_q;
	logic                   dzero_q;
	logic [PROD_W-1:0]      prod_q;
	logic [SPEED_WIDTH-1:0] rem_q;

	logic [SPEED_WIDTH:0]   dx;
	logic [SPEED_WIDTH:0]   den;
	logic [TIME_WIDTH:0]    dy;
	logic [SPEED_WIDTH:0]   dx_abs;
	logic [SPEED_WIDTH:0]   den_abs;
	logic [TIME_WIDTH:0]    dy_abs;
	logic [PROD_W-1:0]      prod;
	logic [SPEED_WIDTH:0]   r2;
	logic [SPEED_WIDTH+1:0] diff;
	logic                   ge;
	logic [SPEED_WIDTH-1:0] rem_nxt;
	logic [TIME_WIDTH:0]    qsat;
	logic [TIME_WIDTH+1:0]  pmin_x;
	logic [TIME_WIDTH+1:0]  q_x;
	logic [TIME_WIDTH+1:0]  res;

	// differences and magnitudes; every magnitude fits the unsigned field width
	assign dx      = {cur_speed[SPEED_WIDTH-1], cur_speed} - {speed_min[SPEED_WIDTH-1], speed_min};
	assign den     = {speed_max[SPEED_WIDTH-1], speed_max} - {speed_min[SPEED_WIDTH-1], speed_min};
	assign dy      = {1'b0, pulse_max} - {1'b0, pulse_min};
	assign dx_abs  = dx[SPEED_WIDTH] ? (~dx + 1'b1) : dx;
	assign den_abs = den[SPEED_WIDTH] ? (~den + 1'b1) : den;
	assign dy_abs  = dy[TIME_WIDTH] ? (~dy + 1'b1) : dy;

	assign prod = ax_q * ay_q;

	// one restoring step a cycle, quotient bits shift in behind the dividend
	assign r2      = {rem_q, prod_q[PROD_W-1]};
	assign diff    = {1'b0, r2} - {2'b00, den_q};
	assign ge      = !diff[SPEED_WIDTH+1];
	assign rem_nxt = ge ? diff[SPEED_WIDTH-1:0] : r2[SPEED_WIDTH-1:0];

	// any quotient of one full range or more saturates the on-time either way
	assign qsat   = (|prod_q[PROD_W-1:TIME_WIDTH]) ? {1'b1, {TIME_WIDTH{1'b0}}}
	                                               : {1'b0, prod_q[TIME_WIDTH-1:0]};
	assign pmin_x = {2'b00, pulse_min};
	assign q_x    = {1'b0, qsat};
	assign res    = neg_q ? (pmin_x - q_x) : (pmin_x + q_x);

	always_comb begin
		if (dzero_q) begin
			on_time = pulse_min;
		end else if (res[TIME_WIDTH+1]) begin
			on_time = '0;
		end else if (res[TIME_WIDTH]) begin
			on_time = '1;
		end else begin
			on_time = res[TIME_WIDTH-1:0];
		end
	end

	assign done = (state_q == M_FIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				M_IDLE: begin
					if (start) begin
						state_q <= (den == '0) ? M_FIN : M_MUL;
					end
				end
				M_MUL: begin
					cnt_q   <= CNT_W'(PROD_W);
					state_q <= M_DIV;
				end
				M_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= M_FIN;
					end
				end
				M_FIN: state_q <= M_IDLE;
				default: state_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				if (start) begin
					ax_q    <= dx_abs[SPEED_WIDTH-1:0];
					ay_q    <= dy_abs[TIME_WIDTH-1:0];
					den_q   <= den_abs[SPEED_WIDTH-1:0];
					neg_q   <= dx[SPEED_WIDTH] ^ dy[TIME_WIDTH] ^ den[SPEED_WIDTH];
					dzero_q <= (den == '0);
				end
			end
			M_MUL: begin
				prod_q <= prod;
				rem_q  <= '0;
			end
			M_DIV: begin
				prod_q <= {prod_q[PROD_W-2:0], ge};
				rem_q  <= rem_nxt;
			end
			default: begin
			end
		endcase
	end

endmodule

// File: src/rpmd_back.sv
module rpmd_back import rpmd_pkg::*; #(
	parameter int SPEED_WIDTH = SPEED_WIDTH_DEF,
	parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [2+SPEED_WIDTH+TIME_WIDTH-1:0] q_head,
	input  logic                                q_empty,
	output logic                                q_pop,
	input  logic [SPEED_WIDTH-1:0]              speed_init,
	input  logic [STEP_WIDTH-1:0]               speed_step,
	input  logic [TIME_WIDTH-1:0]               pulse_period,
	output logic [SPEED_WIDTH-1:0]              cur_speed,
	output logic                                map_start,
	input  logic                                map_done,
	input  logic [TIME_WIDTH-1:0]               map_on_time,
	rpmd_status_if.source                       status,
	output rpmd_back_stat_t                     stat
);
	localparam int ENTRY_W = 2 + SPEED_WIDTH + TIME_WIDTH;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_RAMP  = 2'd1;
	localparam logic [1:0] S_START = 2'd2;
	localparam logic [1:0] S_WAIT  = 2'd3;

	logic [1:0]             state_q;
	logic [SPEED_WIDTH-1:0] cur_q;
	logic [SPEED_WIDTH-1:0] tgt_q;
	logic [TIME_WIDTH-1:0]  on_q;
	logic [TIME_WIDTH:0]    acc_q;
	logic                   level_q;
	logic                   pend_q;
	logic                   res_valid_q;
	rpmd_result_t           res_q;

	logic [1:0]             head_op;
	logic [SPEED_WIDTH-1:0] head_val;
	logic [TIME_WIDTH-1:0]  head_ivl;
	logic                   head_pending;
	logic                   out_free;
	logic                   exec;
	logic [TIME_WIDTH:0]    acc_sum;

	logic [SPEED_WIDTH-1:0] nxt_cur;
	logic [SPEED_WIDTH-1:0] nxt_tgt;
	logic [TIME_WIDTH-1:0]  nxt_on;
	logic [TIME_WIDTH:0]    nxt_acc;
	logic                   nxt_level;
	logic                   nxt_pend;
	logic                   pe;

	logic signed [SPEED_WIDTH+1:0] cur_x;
	logic signed [SPEED_WIDTH+1:0] tgt_x;
	logic signed [SPEED_WIDTH+1:0] step_x;
	logic signed [SPEED_WIDTH+1:0] up_x;
	logic signed [SPEED_WIDTH+1:0] dn_x;
	logic                          tgt_pos;
	logic [SPEED_WIDTH-1:0]        ramp_val;

	assign head_op  = q_head[ENTRY_W-1 -: 2];
	assign head_val = q_head[SPEED_WIDTH+TIME_WIDTH-1 -: SPEED_WIDTH];
	assign head_ivl = q_head[TIME_WIDTH-1:0];

	assign head_pending = (head_op == OP_TICK) && pend_q;
	assign out_free     = !res_valid_q || status.ready;
	assign exec         = (state_q == S_IDLE) && !q_empty && !head_pending && out_free;
	assign q_pop        = exec;
	assign map_start    = (state_q == S_START);
	assign cur_speed    = cur_q;

	// one step toward the target; an overshoot or a wrong-way step lands on it
	assign cur_x    = {{2{cur_q[SPEED_WIDTH-1]}}, cur_q};
	assign tgt_x    = {{2{tgt_q[SPEED_WIDTH-1]}}, tgt_q};
	assign step_x   = {{(SPEED_WIDTH+2-STEP_WIDTH){1'b0}}, speed_step};
	assign up_x     = cur_x + step_x;
	assign dn_x     = cur_x - step_x;
	assign tgt_pos  = !tgt_q[SPEED_WIDTH-1] && (tgt_q != '0);
	assign ramp_val = tgt_pos ? ((up_x >= tgt_x) ? tgt_q : up_x[SPEED_WIDTH-1:0])
	                          : ((dn_x <= tgt_x) ? tgt_q : dn_x[SPEED_WIDTH-1:0]);

	assign acc_sum = acc_q + {1'b0, head_ivl};

	always_comb begin
		nxt_cur   = cur_q;
		nxt_tgt   = tgt_q;
		nxt_on    = on_q;
		nxt_acc   = acc_q;
		nxt_level = level_q;
		nxt_pend  = pend_q;
		pe        = 1'b0;
		case (head_op)
			OP_TICK: begin
				if (acc_sum < {1'b0, pulse_period}) begin
					nxt_acc   = acc_sum;
					nxt_level = (acc_sum < {1'b0, on_q});
				end else begin
					nxt_acc   = '0;
					nxt_level = 1'b0;
					pe        = 1'b1;
				end
				nxt_pend = pe;
			end
			OP_SET: nxt_tgt = head_val;
			OP_READY: begin
				nxt_cur   = speed_init;
				nxt_tgt   = speed_init;
				nxt_on    = '0;
				nxt_acc   = '0;
				nxt_level = 1'b0;
				nxt_pend  = 1'b1;
			end
			OP_NOP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q   <= SPEED_WIDTH'(SPEED_INIT_RST);
			tgt_q   <= SPEED_WIDTH'(SPEED_INIT_RST);
			on_q    <= '0;
			acc_q   <= '0;
			level_q <= 1'b0;
			pend_q  <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (!q_empty && head_pending) begin
						state_q <= S_RAMP;
					end else if (exec) begin
						cur_q   <= nxt_cur;
						tgt_q   <= nxt_tgt;
						on_q    <= nxt_on;
						acc_q   <= nxt_acc;
						level_q <= nxt_level;
						pend_q  <= nxt_pend;
					end
				end
				S_RAMP: begin
					cur_q   <= ramp_val;
					state_q <= S_START;
				end
				S_START: state_q <= S_WAIT;
				S_WAIT: begin
					if (map_done) begin
						on_q    <= map_on_time;
						pend_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// hold the result until its transfer, reload it when the next command retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (exec) begin
			res_valid_q <= 1'b1;
		end else if (status.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			res_q.motor_on    <= nxt_level;
			res_q.period_end  <= pe;
			res_q.forward     <= !nxt_cur[SPEED_WIDTH-1];
			res_q.target_zero <= (nxt_tgt == '0);
		end
	end

	assign status.valid       = res_valid_q;
	assign status.motor_on    = res_q.motor_on;
	assign status.period_end  = res_q.period_end;
	assign status.forward     = res_q.forward;
	assign status.target_zero = res_q.target_zero;

	assign stat.idle           = (state_q == S_IDLE);
	assign stat.map_wait       = (state_q == S_WAIT);
	assign stat.recompute_pend = pend_q;

endmodule

// File: dv/ramped_pwm_motor_drive_core_tb.sv
module ramped_pwm_motor_drive_core_tb import rpmd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// Tracks the drive state per command and holds the status words still owed by the block.
	class pwm_status_scoreboard;
		logic signed [15:0] lim_lo, lim_hi, init_speed;
		logic [7:0]         ramp_step;
		logic [15:0]        pulse_lo, pulse_hi, period_len;
		logic signed [15:0] speed_now, speed_goal;
		logic [15:0]        on_len;
		logic [16:0]        accum;
		bit                 level, remap_due;
		rpmd_result_t       expected_status[$];
		int                 failures, checked, commands, ticks, period_ends;

		function new();
			lim_lo     = 16'(SPEED_MIN_RST);
			lim_hi     = 16'(SPEED_MAX_RST);
			init_speed = 16'(SPEED_INIT_RST);
			ramp_step  = 8'(SPEED_STEP_RST);
			pulse_lo   = 16'(PULSE_MIN_RST);
			pulse_hi   = 16'(PULSE_MAX_RST);
			period_len = 16'(PULSE_PERIOD_RST);
			load_ready();
		endfunction

		function void load_ready();
			speed_now  = init_speed;
			speed_goal = init_speed;
			on_len     = '0;
			accum      = '0;
			level      = 1'b0;
			remap_due  = 1'b1;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
			case (idx)
				REG_SPEED_MIN:    lim_lo = data;
				REG_SPEED_MAX:    lim_hi = data;
				REG_SPEED_INIT:   init_speed = data;
				REG_SPEED_STEP:   ramp_step = data[7:0];
				REG_PULSE_MIN:    pulse_lo = data;
				REG_PULSE_MAX:    pulse_hi = data;
				REG_PULSE_PERIOD: period_len = data;
				default: ;
			endcase
		endfunction

		// linear map of speed onto the pulse range, quotient truncated, result saturated
		function logic [15:0] map_on_time();
			longint dx, dy, den, q, res;
			bit     neg;
			dx  = longint'(speed_now) - longint'(lim_lo);
			dy  = longint'(pulse_hi) - longint'(pulse_lo);
			den = longint'(lim_hi) - longint'(lim_lo);
			if (den == 0)
				return pulse_lo;
			q   = ((dx < 0 ? -dx : dx) * (dy < 0 ? -dy : dy)) / (den < 0 ? -den : den);
			neg = ((dx < 0) != (dy < 0)) != (den < 0);
			res = neg ? longint'(pulse_lo) - q : longint'(pulse_lo) + q;
			if (res < 0)
				return 16'h0000;
			if (res > 65535)
				return 16'hFFFF;
			return res[15:0];
		endfunction

		function void advance_speed();
			longint s;
			if (speed_now != speed_goal) begin
				s = longint'(speed_now);
				if (speed_goal > 0) begin
					s = s + longint'(ramp_step);
					if (s >= speed_goal)
						s = speed_goal;
				end else begin
					s = s - longint'(ramp_step);
					if (s <= speed_goal)
						s = speed_goal;
				end
				speed_now = s[15:0];
			end
			on_len = map_on_time();
		endfunction

		function void note_command(logic [1:0] op, logic signed [15:0] tv, logic [15:0] ti);
			rpmd_result_t r;
			bit           closed;
			longint       t;
			closed = 1'b0;
			commands++;
			case (op)
				OP_TICK: begin
					ticks++;
					if (remap_due)
						advance_speed();
					accum = accum + {1'b0, ti};
					if (accum < {1'b0, period_len}) begin
						level = accum < {1'b0, on_len};
					end else begin
						level  = 1'b0;
						accum  = '0;
						closed = 1'b1;
						period_ends++;
					end
					remap_due = closed;
				end
				OP_SET: begin
					t = longint'(tv);
					if (t > lim_hi)
						t = lim_hi;
					if (t < lim_lo)
						t = lim_lo;
					speed_goal = t[15:0];
				end
				OP_READY: load_ready();
				default: ;
			endcase
			r.motor_on    = level;
			r.period_end  = closed;
			r.forward     = !speed_now[15];
			r.target_zero = (speed_goal == 0);
			expected_status.push_back(r);
		endfunction

		function void report(string what, rpmd_result_t want, rpmd_result_t got);
			failures++;
			if (failures <= 10) begin
				$display("[%0t] status %0d %s: expected on=%b end=%b fwd=%b tz=%b",
					$time, checked, what, want.motor_on, want.period_end, want.forward,
					want.target_zero);
				$display("    got on=%b end=%b fwd=%b tz=%b",
					got.motor_on, got.period_end, got.forward, got.target_zero);
			end
		endfunction

		function void check_status(rpmd_result_t got);
			rpmd_result_t want;
			string        bad;
			bad = "";
			if (expected_status.size() == 0) begin
				report("unexpected, nothing outstanding", '0, got);
				return;
			end
			want = expected_status.pop_front();
			checked++;
			if (got.motor_on !== want.motor_on)
				bad = {bad, " motor_on"};
			if (got.period_end !== want.period_end)
				bad = {bad, " period_end"};
			if (got.forward !== want.forward)
				bad = {bad, " forward"};
			if (got.target_zero !== want.target_zero)
				bad = {bad, " target_zero"};
			if (bad != "")
				report({"mismatch in", bad}, want, got);
		endfunction

		function int outstanding();
			return expected_status.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   tx_idle_pct;
	int   rx_idle_pct;
	bit   hold_req;
	int   settings_used;

	pwm_status_scoreboard status_sb;

	rpmd_cfg_if    cfg_bus ();
	rpmd_cmd_if    cmd_bus ();
	rpmd_status_if status_bus ();

	ramped_pwm_motor_drive_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.cmd    (cmd_bus),
		.status (status_bus)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Uniform pick in [lo, hi]; the span never exceeds 32 bits here.
	function automatic longint rand_in(longint lo, longint hi);
		return lo + longint'($urandom_range(32'(hi - lo)));
	endfunction

	// Offer one command, idling the channel first at the current sender rate. Valid is
	// left high after the transfer; the next negedge either replaces the item or drops it.
	task automatic send_command(input logic [1:0] op, input logic signed [15:0] tv,
		input logic [15:0] ti);
		while ($urandom_range(99) < tx_idle_pct) begin
			@(negedge clk);
			cmd_bus.valid = 1'b0;
		end
		@(negedge clk);
		cmd_bus.op            = op;
		cmd_bus.target_value  = tv;
		cmd_bus.tick_interval = ti;
		cmd_bus.valid         = 1'b1;
		do @(posedge clk); while (cmd_bus.ready !== 1'b1);
		status_sb.note_command(op, tv, ti);
	endtask

	// Drop valid and hold until every owed status word has been seen.
	task automatic drain();
		@(negedge clk);
		cmd_bus.valid = 1'b0;
		while (status_sb.outstanding() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_bus.index = idx;
		cfg_bus.data  = data;
		cfg_bus.valid = 1'b1;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		status_sb.write_reg(idx, data);
	endtask

	// Write the whole register set; only ever called with the command side drained.
	task automatic apply_setting(input logic [15:0] lo, input logic [15:0] hi,
		input logic [15:0] init, input logic [7:0] step_sz, input logic [15:0] plo,
		input logic [15:0] phi, input logic [15:0] per);
		write_register(REG_SPEED_MIN, lo);
		write_register(REG_SPEED_MAX, hi);
		write_register(REG_SPEED_INIT, init);
		write_register(REG_SPEED_STEP, {8'h00, step_sz});
		write_register(REG_PULSE_MIN, plo);
		write_register(REG_PULSE_MAX, phi);
		write_register(REG_PULSE_PERIOD, per);
		@(negedge clk);
		cfg_bus.valid = 1'b0;
		settings_used++;
	endtask

	// Shapes of register set: full span, flat map, inverted limits, start far outside the
	// limits (map saturates), otherwise a modest window. Periods are mostly short so
	// that the ramp runs often.
	task automatic random_setting(input int kind);
		longint lo, hi, init, lo_s, hi_s;
		int     step_sz, pulse_a, pulse_b, per, sel;
		case (kind)
			0: begin
				lo = -32768;
				hi = 32767;
			end
			1: begin
				lo = rand_in(-1000, 1000);
				hi = lo;
			end
			2: begin
				hi = rand_in(-500, 400);
				lo = rand_in(hi + 1, hi + 600);
			end
			3: begin
				lo = rand_in(-20, 0);
				hi = rand_in(lo + 1, lo + 20);
			end
			default: begin
				lo = rand_in(-400, 300);
				hi = rand_in(lo + 1, lo + 700);
			end
		endcase
		sel = $urandom_range(99);
		if (sel < 60)
			per = $urandom_range(1, 300);
		else if (sel < 85)
			per = $urandom_range(300, 5000);
		else
			per = $urandom_range(60000, 65535);
		step_sz = ($urandom_range(99) < 70) ? $urandom_range(1, 40) : $urandom_range(1, 255);
		pulse_a = $urandom_range(1) ? $urandom_range(per) : $urandom_range(65535);
		pulse_b = $urandom_range(1) ? $urandom_range(per) : $urandom_range(65535);
		lo_s = (lo < hi) ? lo : hi;
		hi_s = (lo < hi) ? hi : lo;
		init = ($urandom_range(99) < 70) ? rand_in(lo_s, hi_s) : rand_in(-32768, 32767);
		if (kind == 0) begin
			step_sz = 255;
			pulse_a = 65535;
			pulse_b = 0;
			per     = 65535;
			init    = -32768;
		end
		if (kind == 3)
			init = $urandom_range(1) ? 32767 : -32768;
		apply_setting(16'(lo), 16'(hi), 16'(init), 8'(step_sz), 16'(pulse_a), 16'(pulse_b),
			16'(per));
	endtask

	// Mostly ticks with intervals scaled to the period, then target changes, a few
	// ready commands and the odd unused op code.
	task automatic random_command();
		int                 r, sel;
		logic [1:0]         op;
		logic signed [15:0] tv;
		logic [15:0]        ti;
		longint             lo_s, hi_s;
		tv = 16'($urandom);
		ti = 16'($urandom);
		r  = $urandom_range(99);
		if (r < 72) begin
			op  = OP_TICK;
			sel = $urandom_range(99);
			if (sel < 50)
				ti = 16'($urandom_range(status_sb.period_len));
			else if (sel < 75)
				ti = 16'($urandom_range(status_sb.period_len / 4 + 1));
			else if (sel < 85)
				ti = '0;
			else if (sel >= 95)
				ti = 16'hFFFF;
		end else if (r < 88) begin
			op   = OP_SET;
			lo_s = (status_sb.lim_lo < status_sb.lim_hi) ? status_sb.lim_lo : status_sb.lim_hi;
			hi_s = (status_sb.lim_lo < status_sb.lim_hi) ? status_sb.lim_hi : status_sb.lim_lo;
			sel  = $urandom_range(99);
			if (sel < 75) begin
				tv = 16'(rand_in(lo_s - 20, hi_s + 20));
			end else if (sel >= 90) begin
				case ($urandom_range(2))
					0: tv = 16'sh8000;
					1: tv = 16'sh7FFF;
					default: tv = '0;
				endcase
			end
		end else if (r < 95) begin
			op = OP_READY;
		end else begin
			op = OP_NOP;
		end
		send_command(op, tv, ti);
	endtask

	// Status receiver: accept at the current rate, or hold off once for a long stretch
	// when asked so that the internal queue fills and the command side stalls.
	initial begin
		bit stall_done;
		stall_done       = 1'b0;
		status_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !stall_done) begin
				stall_done       = 1'b1;
				status_bus.ready = 1'b0;
				repeat (400) @(negedge clk);
			end else begin
				status_bus.ready = ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Check every status transfer against the oldest owed word.
	initial begin
		rpmd_result_t seen;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (status_bus.valid === 1'b1 && status_bus.ready === 1'b1) begin
				seen.motor_on    = status_bus.motor_on;
				seen.period_end  = status_bus.period_end;
				seen.forward     = status_bus.forward;
				seen.target_zero = status_bus.target_zero;
				status_sb.check_status(seen);
			end
		end
	end

	initial begin
		#8_000_000;
		$display("run limit reached with %0d status words outstanding", status_sb.outstanding());
		$display("[ramped_pwm_motor_drive_core] ERROR");
		$finish;
	end

	initial begin
		status_sb             = new();
		arst_n                = 1'b0;
		hold_req              = 1'b0;
		settings_used         = 0;
		tx_idle_pct           = 15;
		rx_idle_pct           = 70;
		cmd_bus.valid         = 1'b0;
		cmd_bus.op            = OP_TICK;
		cmd_bus.target_value  = '0;
		cmd_bus.tick_interval = '0;
		cfg_bus.valid         = 1'b0;
		cfg_bus.index         = REG_SPEED_MIN;
		cfg_bus.data          = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// Reset values first: flat zero pulse, target clamped to the upper limit,
		// and a tick that exactly fills the default period.
		send_command(OP_TICK, 16'sd0, 16'd0);
		send_command(OP_SET, 16'sd300, 16'd0);
		send_command(OP_TICK, 16'sd0, 16'd20000);
		drain();

		// Small window, coarse step and a short period so every ramp case shows quickly.
		apply_setting(-16'sd50, 16'sd50, 16'sd0, 8'd20, 16'd100, 16'd900, 16'd1000);
		send_command(OP_TICK, 16'sd0, 16'd0);
		send_command(OP_SET, 16'sh7FFF, 16'hFFFF);
		send_command(OP_TICK, 16'sd0, 16'd1000);
		send_command(OP_TICK, 16'sd0, 16'd600);
		send_command(OP_TICK, 16'sd0, 16'd400);
		send_command(OP_TICK, 16'sd0, 16'hFFFF);
		// step would pass the target: snap to it
		send_command(OP_TICK, 16'sd0, 16'd0);
		send_command(OP_SET, 16'sh8000, 16'd0);
		send_command(OP_TICK, 16'sd0, 16'd1000);
		send_command(OP_TICK, 16'sd0, 16'd1);
		// zero target ramps down and must not undershoot
		send_command(OP_SET, 16'sd0, 16'd0);
		send_command(OP_TICK, 16'sd0, 16'd999);
		send_command(OP_TICK, 16'sd0, 16'd5);
		send_command(OP_TICK, 16'sd0, 16'd995);
		send_command(OP_TICK, 16'sd0, 16'd0);
		// positive target below the speed: stepping the wrong way lands on the target
		send_command(OP_SET, 16'sd50, 16'd0);
		send_command(OP_TICK, 16'sd0, 16'd1000);
		send_command(OP_TICK, 16'sd0, 16'd1000);
		send_command(OP_TICK, 16'sd0, 16'd1000);
		send_command(OP_SET, 16'sd10, 16'd0);
		send_command(OP_TICK, 16'sd0, 16'd300);
		send_command(OP_NOP, 16'sh7FFF, 16'hFFFF);
		send_command(OP_READY, 16'sh8000, 16'hFFFF);
		send_command(OP_TICK, 16'sd0, 16'd0);

		for (int phase = 1; phase <= 12; phase++) begin
			drain();
			random_setting(phase <= 4 ? phase - 1 : $urandom_range(4, 9));
			if (phase <= 4) begin
				tx_idle_pct = 15;
				rx_idle_pct = 70;
			end else if (phase <= 8) begin
				tx_idle_pct = 70;
				rx_idle_pct = 15;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			for (int n = 0; n < 158; n++) begin
				random_command();
				// long status stall while commands keep coming
				if (phase == 2 && n == 80)
					hold_req = 1'b1;
				// pause the sender until the block has caught up completely
				if (phase == 6 && n == 80)
					drain();
			end
		end

		drain();
		repeat (60) @(posedge clk);

		$display("Drove %0d commands (%0d ticks, %0d period ends) through %0d register sets,",
			status_sb.commands, status_sb.ticks, status_sb.period_ends, settings_used);
		$display("idling both sides, a long status stall, a mid-run drain; %0d failures.",
			status_sb.failures);
		if (status_sb.failures == 0 && status_sb.outstanding() == 0)
			$display("[ramped_pwm_motor_drive_core] OK");
		else
			$display("[ramped_pwm_motor_drive_core] ERROR");
		$finish;
	end

endmodule
